### rtl/hum_pkg.sv
package hum_pkg;

	// field widths
	localparam int unsigned KIND_W     = 3;
	localparam int unsigned TIME_W     = 16;
	localparam int unsigned LOAD_W     = 32;
	localparam int unsigned TICK_W     = 24;
	localparam int unsigned STEP_W     = 8;
	localparam int unsigned BARS_W     = 4;
	localparam int unsigned PCT_W      = 7;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	// shared divider: left-aligned dividend, one quotient bit per cycle
	localparam int unsigned DIV_NUM_W = 32;
	localparam int unsigned DIV_DEN_W = 24;
	localparam int unsigned DIV_LEN_W = $clog2(DIV_NUM_W + 1);
	localparam int unsigned PROD_W    = TICK_W + PCT_W;

	// register reset values
	localparam logic [STEP_W-1:0] TICK_MS_RST   = 8'd10;
	localparam logic [TICK_W-1:0] SEG_TICKS_RST = 24'd60000;
	localparam logic [TICK_W-1:0] EMPTY_RST     = 24'd340000;
	localparam logic [TICK_W-1:0] SAVE_INT_RST  = 24'd1000;
	localparam logic [BARS_W-1:0] SEG_COUNT_RST = 4'd6;
	localparam logic [PCT_W-1:0]  PCT_SCALE     = 7'd100;

	typedef enum logic [KIND_W-1:0] {
		KIND_INIT       = 3'd0,
		KIND_UPDATE     = 3'd1,
		KIND_COIL_ON    = 3'd2,
		KIND_COIL_OFF   = 3'd3,
		KIND_COIL_PAUSE = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_MS       = 3'd0,
		CFG_SEG_TICKS     = 3'd1,
		CFG_EMPTY_TICKS   = 3'd2,
		CFG_SAVE_INTERVAL = 3'd3,
		CFG_SEG_COUNT     = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
		logic [DIV_LEN_W-1:0] len;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
		logic [DIV_DEN_W-1:0] rem;
	} div_rsp_t;

endpackage

### rtl/hum_ifs.sv
interface hum_evt_if;
	import hum_pkg::*;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [TIME_W-1:0] now_ms;
	logic [LOAD_W-1:0] load_ticks;
	modport source(output valid, kind, now_ms, load_ticks, input ready);
	modport sink(input valid, kind, now_ms, load_ticks, output ready);
endinterface

interface hum_res_if;
	import hum_pkg::*;
	logic              valid;
	logic              ready;
	logic [BARS_W-1:0] bars_left;
	logic [PCT_W-1:0]  percent_left;
	logic [TICK_W-1:0] used_ticks;
	logic              save_request;
	logic              coil_active;
	modport source(output valid, bars_left, percent_left, used_ticks, save_request,
		coil_active, input ready);
	modport sink(input valid, bars_left, percent_left, used_ticks, save_request,
		coil_active, output ready);
endinterface

interface hum_cfg_if;
	import hum_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/hum_div.sv
module hum_div (
	input  logic              clk,
	input  logic              arst_n,
	input  hum_pkg::div_req_t req,
	output hum_pkg::div_rsp_t rsp
);
	import hum_pkg::*;

	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_LEN_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   shifted;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	// restoring step: borrow out of the subtract means the divisor does not fit
	assign shifted = {rem_q, quo_q[DIV_NUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = ~trial[DIV_DEN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.len;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_LEN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
			rem_q <= fits ? trial[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

### rtl/heater_usage_meter.sv
// Heater usage meter. Each event transfer (init, update, coil on, coil off,
// coil pause, with a 16-bit millisecond timestamp) yields exactly one result
// transfer carrying the remaining bars, the remaining percent, the tick total,
// a save request and the coil state. All divisions run through one shared
// restoring divider that retires one quotient bit per cycle: the ms-to-tick
// split (16 bits), the bars quotient (24 bits) and the percent quotient
// (31 bits) take their turn on it, with one 24x7 multiply in between. The
// ms-to-tick split runs only when the coil is on and elapsed time is
// accounted, and the bars and percent divisions are skipped when the gauge
// is already empty; the event channel is not ready while an event is processed.
// A finished result sits in the output register, so the next event is taken
// while it waits. Configuration registers are written through the cfg channel
// (always ready), by the user only while the block is idle; the block itself
// does not enforce this. Unknown register indexes are ignored.
module heater_usage_meter (
	input logic       clk,
	input logic       arst_n,
	hum_evt_if.sink   evt,
	hum_res_if.source res,
	hum_cfg_if.sink   cfg
);
	import hum_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_ACC_WAIT,
		ST_SAVE,
		ST_GAUGE,
		ST_BARS_WAIT,
		ST_PCT_MUL,
		ST_PCT_DIV,
		ST_PCT_WAIT,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration
	logic [STEP_W-1:0] tick_ms_q;
	logic [TICK_W-1:0] seg_ticks_q;
	logic [TICK_W-1:0] empty_q;
	logic [TICK_W-1:0] save_int_q;
	logic [BARS_W-1:0] seg_count_q;

	// latched event
	logic [KIND_W-1:0] kind_q;
	logic [TIME_W-1:0] now_q;
	logic [LOAD_W-1:0] load_q;

	// meter state
	logic [TICK_W-1:0] tick_q;
	logic [TICK_W-1:0] saved_tot_q;
	logic [TIME_W-1:0] last_q;
	logic [STEP_W-1:0] carry_q;
	logic              coil_q;
	logic              dirty_q;
	logic              saved_q;

	// gauge working registers
	logic [BARS_W-1:0] bars_q;
	logic [PCT_W-1:0]  pct_q;
	logic [TICK_W-1:0] diff_q;
	logic [PROD_W-1:0] prod_q;

	// result register
	logic              res_valid_q;
	logic [BARS_W-1:0] res_bars_q;
	logic [PCT_W-1:0]  res_pct_q;
	logic [TICK_W-1:0] res_used_q;
	logic              res_save_q;
	logic              res_coil_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic [STEP_W-1:0] step;
	logic [TICK_W-1:0] seg;
	logic [TIME_W-1:0] acc_total;
	logic [TIME_W-1:0] fresh;
	logic [TICK_W:0]   acc_sum;
	logic [TICK_W-1:0] load_clamped;
	logic              is_acc_kind;
	logic              below_empty;

	// a zero divisor register counts as one
	assign step = (tick_ms_q == '0) ? STEP_W'(1) : tick_ms_q;
	assign seg  = (seg_ticks_q == '0) ? TICK_W'(1) : seg_ticks_q;

	// elapsed ms plus the carried remainder, wrapping at 16 bits
	assign acc_total = now_q - last_q + TIME_W'(carry_q);
	assign fresh     = div_rsp.quo[TIME_W-1:0];
	// tick_q < empty_q holds here, so overshooting empty is the saturation test
	assign acc_sum   = {1'b0, tick_q} + (TICK_W + 1)'(fresh);

	assign load_clamped = (load_q > LOAD_W'(empty_q)) ? empty_q : load_q[TICK_W-1:0];
	assign below_empty  = tick_q < empty_q;
	assign is_acc_kind  = (kind_q == KIND_UPDATE) || (kind_q == KIND_COIL_OFF) ||
		(kind_q == KIND_COIL_PAUSE);

	// divider requests; dividends are left-aligned so the quotient lands low
	always_comb begin
		div_req = '0;
		unique case (state_q)
			ST_EXEC: begin
				div_req.start = is_acc_kind && coil_q;
				div_req.num   = {acc_total, {(DIV_NUM_W - TIME_W){1'b0}}};
				div_req.den   = DIV_DEN_W'(step);
				div_req.len   = DIV_LEN_W'(TIME_W);
			end
			ST_GAUGE: begin
				div_req.start = below_empty;
				div_req.num   = {tick_q, {(DIV_NUM_W - TICK_W){1'b0}}};
				div_req.den   = seg;
				div_req.len   = DIV_LEN_W'(TICK_W);
			end
			ST_PCT_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = {prod_q, {(DIV_NUM_W - PROD_W){1'b0}}};
				div_req.den   = empty_q;
				div_req.len   = DIV_LEN_W'(PROD_W);
			end
			default: begin
				div_req = '0;
			end
		endcase
	end

	hum_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ms_q   <= TICK_MS_RST;
			seg_ticks_q <= SEG_TICKS_RST;
			empty_q     <= EMPTY_RST;
			save_int_q  <= SAVE_INT_RST;
			seg_count_q <= SEG_COUNT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_TICK_MS:       tick_ms_q   <= cfg.data[STEP_W-1:0];
				CFG_SEG_TICKS:     seg_ticks_q <= cfg.data[TICK_W-1:0];
				CFG_EMPTY_TICKS:   empty_q     <= cfg.data[TICK_W-1:0];
				CFG_SAVE_INTERVAL: save_int_q  <= cfg.data[TICK_W-1:0];
				CFG_SEG_COUNT:     seg_count_q <= cfg.data[BARS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign evt.ready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			kind_q      <= '0;
			now_q       <= '0;
			load_q      <= '0;
			tick_q      <= '0;
			saved_tot_q <= '0;
			last_q      <= '0;
			carry_q     <= '0;
			coil_q      <= 1'b0;
			dirty_q     <= 1'b0;
			saved_q     <= 1'b0;
			bars_q      <= '0;
			pct_q       <= '0;
			diff_q      <= '0;
			prod_q      <= '0;
			res_valid_q <= 1'b0;
			res_bars_q  <= '0;
			res_pct_q   <= '0;
			res_used_q  <= '0;
			res_save_q  <= 1'b0;
			res_coil_q  <= 1'b0;
		end else begin
			// drained on transfer; in ST_DONE the hand-over decides
			if (res_valid_q && res.ready && (state_q != ST_DONE)) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (evt.valid) begin
						kind_q  <= evt.kind;
						now_q   <= evt.now_ms;
						load_q  <= evt.load_ticks;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					saved_q <= 1'b0;
					unique case (kind_q)
						KIND_INIT: begin
							tick_q      <= load_clamped;
							saved_tot_q <= load_clamped;
							last_q      <= now_q;
							carry_q     <= '0;
							coil_q      <= 1'b0;
							dirty_q     <= 1'b0;
							state_q     <= ST_GAUGE;
						end
						KIND_COIL_ON: begin
							if (!coil_q) begin
								last_q <= now_q;
								coil_q <= 1'b1;
							end
							state_q <= ST_GAUGE;
						end
						KIND_UPDATE, KIND_COIL_OFF, KIND_COIL_PAUSE: begin
							// with the coil on the divider was started this cycle
							if (coil_q) begin
								last_q  <= now_q;
								state_q <= ST_ACC_WAIT;
							end else begin
								state_q <= ST_SAVE;
							end
						end
						default: begin
							state_q <= ST_GAUGE;
						end
					endcase
				end
				ST_ACC_WAIT: begin
					if (div_rsp.done) begin
						carry_q <= div_rsp.rem[STEP_W-1:0];
						if ((fresh != '0) && below_empty) begin
							tick_q  <= (acc_sum >= {1'b0, empty_q}) ? empty_q :
								acc_sum[TICK_W-1:0];
							dirty_q <= 1'b1;
						end
						state_q <= ST_SAVE;
					end
				end
				ST_SAVE: begin
					unique case (kind_q)
						KIND_UPDATE: begin
							if (dirty_q && ((tick_q - saved_tot_q) >= save_int_q)) begin
								saved_tot_q <= tick_q;
								dirty_q     <= 1'b0;
								saved_q     <= 1'b1;
							end
						end
						KIND_COIL_OFF: begin
							coil_q <= 1'b0;
							if (dirty_q) begin
								saved_tot_q <= tick_q;
								dirty_q     <= 1'b0;
								saved_q     <= 1'b1;
							end
						end
						KIND_COIL_PAUSE: begin
							coil_q <= 1'b0;
						end
						default: begin
						end
					endcase
					state_q <= ST_GAUGE;
				end
				ST_GAUGE: begin
					// bars division started here when the gauge is not empty
					if (below_empty) begin
						state_q <= ST_BARS_WAIT;
					end else begin
						bars_q  <= '0;
						pct_q   <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_BARS_WAIT: begin
					if (div_rsp.done) begin
						bars_q  <= (div_rsp.quo >= DIV_NUM_W'(seg_count_q)) ? '0 :
							seg_count_q - div_rsp.quo[BARS_W-1:0];
						diff_q  <= empty_q - tick_q;
						state_q <= ST_PCT_MUL;
					end
				end
				ST_PCT_MUL: begin
					prod_q  <= PROD_W'(diff_q) * PROD_W'(PCT_SCALE);
					state_q <= ST_PCT_DIV;
				end
				ST_PCT_DIV: begin
					state_q <= ST_PCT_WAIT;
				end
				ST_PCT_WAIT: begin
					if (div_rsp.done) begin
						pct_q   <= div_rsp.quo[PCT_W-1:0];
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hand over once the output register is free or draining
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_bars_q  <= bars_q;
						res_pct_q   <= pct_q;
						res_used_q  <= tick_q;
						res_save_q  <= saved_q;
						res_coil_q  <= coil_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid        = res_valid_q;
	assign res.bars_left    = res_bars_q;
	assign res.percent_left = res_pct_q;
	assign res.used_ticks   = res_used_q;
	assign res.save_request = res_save_q;
	assign res.coil_active  = res_coil_q;

	// divider completes only where the sequencer waits for it
	a_div_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_ACC_WAIT || state_q == ST_BARS_WAIT ||
			state_q == ST_PCT_WAIT))
		else $error("divider finished outside a wait state");

	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	a_ready_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		evt.ready |-> !div_rsp.busy)
		else $error("event channel ready with divider in flight");

	a_save_clears_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && saved_q) |-> !dirty_q)
		else $error("save reported with total still dirty");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.percent_left <= PCT_SCALE))
		else $error("percent above full scale");

endmodule

### verif/heater_usage_meter_test.sv
`timescale 1ns / 100ps

module heater_usage_meter_test;
	import hum_pkg::*;

	// Event codes above the last defined kind: the block must leave its state alone.
	localparam logic [KIND_W-1:0] KIND_RSVD_LO  = 3'd5;
	localparam logic [KIND_W-1:0] KIND_RSVD_MID = 3'd6;
	localparam logic [KIND_W-1:0] KIND_RSVD_HI  = 3'd7;

	// With 88% stalls on either side, a quiet stretch that reaches the watchdog
	// limit is already very unlikely.
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TAIL_CYCLES    = 150;
	localparam int PHASE_ITEMS    = 90;
	localparam int PHASES         = 8;
	localparam int OPENING_ROWS   = 25;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

	typedef struct packed {
		logic [BARS_W-1:0] bars;
		logic [PCT_W-1:0]  pct;
		logic [TICK_W-1:0] used;
		logic              save;
		logic              coil;
	} gauge_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] now;
		logic [LOAD_W-1:0] load;
		logic              pinned;
		gauge_t            res;
	} step_row_t;

	typedef struct packed {
		logic [STEP_W-1:0] tick_ms;
		logic [TICK_W-1:0] seg_ticks;
		logic [TICK_W-1:0] empty;
		logic [TICK_W-1:0] save_int;
		logic [BARS_W-1:0] seg_count;
		idle_t             mode;
	} cfg_set_t;

	// Opening sequence, run under the reset settings (10 ms tick, 60000 per bar,
	// 340000 empty, save every 1000, 6 bars). Pinned rows carry the result that
	// can be read straight off; the rest go through the predictor.
	localparam step_row_t OPENING [OPENING_ROWS] = '{
		// fresh out of reset, nothing accounted
		'{KIND_UPDATE,     16'h0000, 32'h0000_0000, 1'b1, '{4'd6, 7'd100, 24'd0,      1'b0, 1'b0}},
		// init far above empty: clamped, gauge empty
		'{KIND_INIT,       16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{4'd0, 7'd0,   24'd340000, 1'b0, 1'b0}},
		'{KIND_COIL_ON,    16'h1234, 32'h0000_0000, 1'b1, '{4'd0, 7'd0,   24'd340000, 1'b0, 1'b1}},
		// empty already: time passes, nothing added, nothing to save
		'{KIND_UPDATE,     16'h9999, 32'h0000_0000, 1'b0, '0},
		'{KIND_COIL_OFF,   16'hA000, 32'h0000_0000, 1'b0, '0},
		'{KIND_INIT,       16'h0000, 32'h0000_0000, 1'b1, '{4'd6, 7'd100, 24'd0,      1'b0, 1'b0}},
		'{KIND_COIL_ON,    16'h0000, 32'h0000_0000, 1'b1, '{4'd6, 7'd100, 24'd0,      1'b0, 1'b1}},
		// short run leaving a remainder, then a long one that triggers a save
		'{KIND_UPDATE,     16'd25,   32'h0000_0000, 1'b0, '0},
		'{KIND_UPDATE,     16'hFFFF, 32'h0000_0000, 1'b0, '0},
		// pause across the timestamp wrap: no save
		'{KIND_COIL_PAUSE, 16'h0009, 32'h0000_0000, 1'b0, '0},
		'{KIND_UPDATE,     16'd100,  32'h0000_0000, 1'b0, '0},
		// coil on twice: the second must not move the timestamp mark
		'{KIND_COIL_ON,    16'd200,  32'h0000_0000, 1'b0, '0},
		'{KIND_COIL_ON,    16'd300,  32'h0000_0000, 1'b0, '0},
		// coil off forces the save, a second coil off has nothing dirty
		'{KIND_COIL_OFF,   16'd1200, 32'h0000_0000, 1'b0, '0},
		'{KIND_COIL_OFF,   16'd1300, 32'h0000_0000, 1'b0, '0},
		// undefined kinds
		'{KIND_RSVD_LO,    16'h5555, 32'hAAAA_AAAA, 1'b0, '0},
		'{KIND_RSVD_MID,   16'hAAAA, 32'h5555_5555, 1'b0, '0},
		'{KIND_RSVD_HI,    16'h0000, 32'hFFFF_FFFF, 1'b0, '0},
		// one tick short of empty, then saturate
		'{KIND_INIT,       16'h0000, 32'd339999,    1'b0, '0},
		'{KIND_COIL_ON,    16'h0000, 32'h0000_0000, 1'b0, '0},
		'{KIND_UPDATE,     16'd40000, 32'h0000_0000, 1'b0, '0},
		'{KIND_UPDATE,     16'd50000, 32'h0000_0000, 1'b0, '0},
		'{KIND_COIL_OFF,   16'd50010, 32'h0000_0000, 1'b0, '0},
		// init exactly at empty and one above
		'{KIND_INIT,       16'd5,    32'd340000,    1'b1, '{4'd0, 7'd0,   24'd340000, 1'b0, 1'b0}},
		'{KIND_INIT,       16'd6,    32'd340001,    1'b1, '{4'd0, 7'd0,   24'd340000, 1'b0, 1'b0}}
	};

	// Register settings per random phase. Several phases set an empty level
	// below the one before, so the parked total lands above it.
	localparam cfg_set_t PLAN [PHASES] = '{
		'{8'd1,   24'd1000,     24'd20000,    24'd500,      4'd15, IDLE_NONE},
		'{8'd255, 24'd16777215, 24'd16777215, 24'd16777215, 4'd15, IDLE_SENDER},
		// zero tick, zero bar size, zero bar count, zero interval
		'{8'd0,   24'd0,        24'd5000,     24'd0,        4'd0,  IDLE_RECEIVER},
		'{8'd10,  24'd60000,    24'd340000,   24'd1000,     4'd6,  IDLE_BOTH},
		// zero empty level: gauge never shows anything
		'{8'd7,   24'd300,      24'd0,        24'd100,      4'd4,  IDLE_NONE},
		'{8'd3,   24'd1,        24'd1,        24'd1,        4'd1,  IDLE_BOTH},
		'{8'd128, 24'd2500,     24'd40000,    24'd3000,     4'd15, IDLE_SENDER},
		'{8'd20,  24'd777,      24'd8000,     24'd200,      4'd11, IDLE_RECEIVER}
	};

	logic clk = 1'b0;
	logic arst_n;

	hum_evt_if evt_ch();
	hum_res_if res_ch();
	hum_cfg_if cfg_ch();

	heater_usage_meter uut (
		.clk    (clk),
		.arst_n (arst_n),
		.evt    (evt_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor copy of the registers and of the meter state.
	logic [STEP_W-1:0] reg_tick_ms   = TICK_MS_RST;
	logic [TICK_W-1:0] reg_seg_ticks = SEG_TICKS_RST;
	logic [TICK_W-1:0] reg_empty     = EMPTY_RST;
	logic [TICK_W-1:0] reg_save_int  = SAVE_INT_RST;
	logic [BARS_W-1:0] reg_seg_count = SEG_COUNT_RST;

	logic [TICK_W-1:0] acc_ticks   = '0;
	logic [TICK_W-1:0] saved_ticks = '0;
	logic [TIME_W-1:0] mark_ms     = '0;
	logic [STEP_W-1:0] spare_ms    = '0;
	logic              coil_on     = 1'b0;
	logic              unsaved     = 1'b0;

	gauge_t gauge_due[$];   // expected results, oldest first
	int     errors = 0;
	int     send_gap_pct = 0;
	int     stall_pct = 0;
	int     quiet_cycles = 0;

	// Sideband travelling with the event: a pinned result replaces the predicted one.
	logic   pin_on;
	gauge_t pin_res;

	// Turn elapsed coil-on time into ticks; remainder carried to the next event.
	function automatic void run_clock(input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] span;
		logic [STEP_W-1:0] step;
		logic [TIME_W-1:0] fresh;
		if (!coil_on)
			return;
		span = now - mark_ms + spare_ms;
		step = (reg_tick_ms == '0) ? STEP_W'(1) : reg_tick_ms;
		fresh = span / step;
		spare_ms = STEP_W'(span % step);
		mark_ms = now;
		if (fresh == '0 || acc_ticks >= reg_empty)
			return;
		if (fresh >= reg_empty - acc_ticks)
			acc_ticks = reg_empty;
		else
			acc_ticks = acc_ticks + fresh;
		unsaved = 1'b1;
	endfunction

	function automatic logic store_due(input logic forced);
		logic [TICK_W-1:0] growth;
		growth = acc_ticks - saved_ticks;
		if (!unsaved || (!forced && growth < reg_save_int))
			return 1'b0;
		saved_ticks = acc_ticks;
		unsaved = 1'b0;
		return 1'b1;
	endfunction

	function automatic gauge_t meter_event(input logic [KIND_W-1:0] kind,
		input logic [TIME_W-1:0] now, input logic [LOAD_W-1:0] load);
		gauge_t            g;
		logic [TICK_W-1:0] seg;
		logic [TICK_W-1:0] spent;
		longint unsigned   left;
		g = '0;
		case (kind)
		KIND_INIT: begin
			acc_ticks = (load > reg_empty) ? reg_empty : load[TICK_W-1:0];
			saved_ticks = acc_ticks;
			mark_ms = now;
			spare_ms = '0;
			coil_on = 1'b0;
			unsaved = 1'b0;
		end
		KIND_UPDATE: begin
			run_clock(now);
			g.save = store_due(1'b0);
		end
		KIND_COIL_ON: begin
			if (!coil_on) begin
				mark_ms = now;
				coil_on = 1'b1;
			end
		end
		KIND_COIL_OFF: begin
			run_clock(now);
			coil_on = 1'b0;
			g.save = store_due(1'b1);
		end
		KIND_COIL_PAUSE: begin
			run_clock(now);
			coil_on = 1'b0;
		end
		default: ;
		endcase
		// gauge reads empty once the total reaches the empty level
		if (acc_ticks < reg_empty) begin
			seg = (reg_seg_ticks == '0) ? TICK_W'(1) : reg_seg_ticks;
			spent = acc_ticks / seg;
			g.bars = (spent >= reg_seg_count) ? '0 : BARS_W'(reg_seg_count - spent);
			left = reg_empty - acc_ticks;
			g.pct = PCT_W'((left * PCT_SCALE) / reg_empty);
		end
		g.used = acc_ticks;
		g.coil = coil_on;
		return g;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want, got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// Receiver side: random back-pressure on results.
	always @(posedge clk)
		res_ch.ready <= ($urandom_range(99) >= stall_pct);

	// Monitor: results checked before the new event's prediction is queued.
	always @(posedge clk) begin
		gauge_t due;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (gauge_due.size() == 0) begin
					$error("result transfer with no event outstanding");
					errors++;
				end else begin
					due = gauge_due.pop_front();
					check_field("bars_left", due.bars, res_ch.bars_left);
					check_field("percent_left", due.pct, res_ch.percent_left);
					check_field("used_ticks", due.used, res_ch.used_ticks);
					check_field("save_request", due.save, res_ch.save_request);
					check_field("coil_active", due.coil, res_ch.coil_active);
				end
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
				CFG_TICK_MS:       reg_tick_ms = cfg_ch.data[STEP_W-1:0];
				CFG_SEG_TICKS:     reg_seg_ticks = cfg_ch.data;
				CFG_EMPTY_TICKS:   reg_empty = cfg_ch.data;
				CFG_SAVE_INTERVAL: reg_save_int = cfg_ch.data;
				CFG_SEG_COUNT:     reg_seg_count = cfg_ch.data[BARS_W-1:0];
				default: ;
				endcase
			end
			if (evt_ch.valid && evt_ch.ready) begin
				due = meter_event(evt_ch.kind, evt_ch.now_ms, evt_ch.load_ticks);
				gauge_due.push_back(pin_on ? pin_res : due);
			end
		end
	end

	// Watchdog: any transfer on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transfer", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic set_idling(input idle_t mode);
		case (mode)
		IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
		IDLE_SENDER:   begin send_gap_pct = 88; stall_pct = 0;  end
		IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 88; end
		default:       begin send_gap_pct = 26; stall_pct = 26; end
		endcase
	endtask

	// Valid stays high straight into the next event unless a gap is rolled.
	task automatic send_event(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] now,
		input logic [LOAD_W-1:0] load, input logic pinned, input gauge_t pinned_res);
		if ($urandom_range(99) < send_gap_pct) begin
			evt_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		evt_ch.valid      <= 1'b1;
		evt_ch.kind       <= kind;
		evt_ch.now_ms     <= now;
		evt_ch.load_ticks <= load;
		pin_on            <= pinned;
		pin_res           <= pinned_res;
		do @(posedge clk); while (!evt_ch.ready);
	endtask

	// Hold off the sender until every outstanding result has been taken.
	task automatic drain_results;
		evt_ch.valid <= 1'b0;
		do @(posedge clk); while (gauge_due.size() != 0);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	// Narrow registers get junk in the unused upper bits; the block must drop it.
	task automatic load_settings(input cfg_set_t s);
		logic [CFG_DATA_W-1:0] pad;
		pad = CFG_DATA_W'($urandom);
		put_reg(CFG_TICK_MS, {pad[CFG_DATA_W-1:STEP_W], s.tick_ms});
		put_reg(CFG_SEG_TICKS, s.seg_ticks);
		put_reg(CFG_EMPTY_TICKS, s.empty);
		put_reg(CFG_SAVE_INTERVAL, s.save_int);
		put_reg(CFG_SEG_COUNT, {pad[CFG_DATA_W-1:BARS_W], s.seg_count});
		// an index past the last register, to be ignored
		put_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, CFG_SEG_COUNT + 1)),
			CFG_DATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [KIND_W-1:0] kind;
		logic [TIME_W-1:0] clock_ms;
		logic [LOAD_W-1:0] load;
		logic [TICK_W-1:0] top;
		int                roll;

		arst_n            = 1'b0;
		evt_ch.valid      = 1'b0;
		evt_ch.kind       = '0;
		evt_ch.now_ms     = '0;
		evt_ch.load_ticks = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = '0;
		cfg_ch.data       = '0;
		pin_on            = 1'b0;
		pin_res           = '0;
		clock_ms          = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(IDLE_NONE);
		for (int r = 0; r < OPENING_ROWS; r++)
			send_event(OPENING[r].kind, OPENING[r].now, OPENING[r].load,
				OPENING[r].pinned, OPENING[r].res);

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			load_settings(PLAN[p]);
			set_idling(PLAN[p].mode);
			top = PLAN[p].empty;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// mid-phase hold-off with the pipe fully drained
				if (i == PHASE_ITEMS / 2)
					drain_results();

				// mostly coil-on runs of updates closed by off or pause,
				// with the odd init and some undefined kinds as noise
				roll = $urandom_range(99);
				if (roll < 4)
					kind = KIND_INIT;
				else if (roll < 14)
					kind = KIND_COIL_ON;
				else if (roll < 22)
					kind = KIND_COIL_OFF;
				else if (roll < 30)
					kind = KIND_COIL_PAUSE;
				else if (roll < 34)
					kind = KIND_W'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
				else
					kind = KIND_UPDATE;

				// timestamp mostly creeps forward, sometimes wraps or jumps
				roll = $urandom_range(99);
				if (roll < 60)
					clock_ms = clock_ms + TIME_W'($urandom_range(300));
				else if (roll < 85)
					clock_ms = clock_ms + TIME_W'($urandom_range(5000));
				else if (roll < 95)
					clock_ms = clock_ms + TIME_W'($urandom_range(65535));
				else
					clock_ms = TIME_W'($urandom);

				// init loads around the empty level as well as the extremes
				case ($urandom_range(5))
				0:       load = '0;
				1:       load = '1;
				2:       load = $urandom;
				3:       load = top + $urandom_range(3);
				4:       load = $urandom_range(top);
				default: load = top - $urandom_range(top < 8 ? top : 8);
				endcase

				send_event(kind, clock_ms, load, 1'b0, '0);
			end
			// park the total at this phase's empty level before the next settings
			send_event(KIND_INIT, clock_ms, '1, 1'b0, '0);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### heater_usage_meter.f
rtl/hum_pkg.sv
rtl/hum_ifs.sv
rtl/hum_div.sv
rtl/heater_usage_meter.sv
verif/heater_usage_meter_test.sv
